### rtl/binom_pkg.sv
// types and constants shared by the binomial coefficient block
`timescale 1ns / 1ps

package binom_pkg;

    localparam int ACC_W   = 64;
    localparam int VALUE_W = 58;
    localparam int FIELD_W = 6;
    localparam int STEP_W  = 5;
    localparam int CNT_W   = 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

### rtl/binomial_coefficient.sv
// binomial coefficient C(n,k) with a shift-add multiplier and a bit-serial exact divider
// m = min(k, n-k) multiply-divide steps per beat, none if m = 0
// each of the m steps first runs the shift-add multiply by (n-m+i)
// and then the restoring divide by i, one quotient bit per cycle
// one beat in flight, the next is taken after the last when the output is free
// i_rst_n is synchronous, active low, and clears the state machine and the output valid
`timescale 1ns / 1ps

module binomial_coefficient
    import binom_pkg::*;
#(
    parameter int MAX_N = 61
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // n [5:0], k [11:6], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // value [57:0], zero pad
);

    t_state r_state, n_state;

    logic [FIELD_W-1:0] r_nm, n_nm;
    logic [STEP_W-1:0]  r_m, n_m;
    logic [STEP_W-1:0]  r_i, n_i;
    logic [FIELD_W-1:0] r_f, n_f;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [ACC_W-1:0]   r_prod, n_prod;
    logic [STEP_W-1:0]  r_rem, n_rem;
    logic [VALUE_W-1:0] r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [FIELD_W-1:0] w_n, w_k, w_nk, w_m6;
    logic [FIELD_W-1:0] w_rem_t, w_div;
    logic               w_qbit;
    logic               w_in_beat, w_load_out, w_last_cnt;

    assign w_n     = s_axis_tdata[5:0];
    assign w_k     = s_axis_tdata[11:6];
    assign w_nk    = w_n - w_k;
    assign w_m6    = (w_k > (w_n >> 1)) ? w_nk : w_k;
    assign w_rem_t = {r_rem, r_prod[ACC_W-1]};
    assign w_div   = {1'b0, r_i};
    assign w_qbit  = (w_rem_t >= w_div);

    // outputs of the state machine
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_load_out    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_last_cnt = (r_state == S_MUL) ? (r_cnt == CNT_W'(FIELD_W - 1))
                                           : (r_cnt == CNT_W'(ACC_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    if ((w_n > FIELD_W'(MAX_N)) || (w_k > w_n) || (w_m6 == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (w_last_cnt) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_last_cnt) begin
                    n_state = (r_i == r_m) ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_nm        = r_nm;
        n_m         = r_m;
        n_i         = r_i;
        n_f         = r_f;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_nm   = w_n - w_m6;
                    n_m    = w_m6[STEP_W-1:0];
                    n_i    = STEP_W'(1);
                    n_f    = w_n - w_m6 + FIELD_W'(1);
                    n_cnt  = '0;
                    n_prod = '0;
                    if ((w_n > FIELD_W'(MAX_N)) || (w_k > w_n)) begin
                        n_acc = '0;
                    end else begin
                        n_acc = ACC_W'(1);
                    end
                end
            end
            S_MUL: begin
                if (r_f[0]) begin
                    n_prod = r_prod + r_acc;
                end
                n_acc = r_acc << 1;
                n_f   = r_f >> 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last_cnt) begin
                    n_cnt = '0;
                    n_rem = '0;
                end
            end
            S_DIV: begin
                n_prod = {r_prod[ACC_W-2:0], w_qbit};
                n_rem  = w_qbit ? STEP_W'(w_rem_t - w_div) : w_rem_t[STEP_W-1:0];
                n_cnt  = r_cnt + CNT_W'(1);
                if (w_last_cnt) begin
                    n_acc  = {r_prod[ACC_W-2:0], w_qbit};
                    n_prod = '0;
                    n_cnt  = '0;
                    n_i    = r_i + STEP_W'(1);
                    n_f    = r_nm + {1'b0, r_i} + FIELD_W'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out       = r_acc[VALUE_W-1:0];
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nm   <= n_nm;
        r_m    <= n_m;
        r_i    <= n_i;
        r_f    <= n_f;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(64 - VALUE_W){1'b0}}, r_out};

endmodule
